[rtl/series_min_median_max_top_assert.svh]
// Assertion macros for the series summary block.
// Used by files that include this header; expects clk and arst_n in scope.
`ifndef SERIES_MIN_MEDIAN_MAX_TOP_ASSERT_SVH
`define SERIES_MIN_MEDIAN_MAX_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SMM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/smm_pkg.sv]
// Shared types and constants for the series summary block.
// No dependencies; the interfaces, adder, top level and verification files import it.
package smm_pkg;

	localparam int SMP_W           = 64;
	localparam int THR_W           = 9;
	localparam int SEEN_W          = 9;
	localparam int SUM_W           = SMP_W + 1;
	localparam int MAX_SAMPLES_DEF = 256;
	localparam logic [THR_W-1:0] THR_RESET = 9'd10;

	typedef enum logic [1:0] {
		KIND_ZERO   = 2'd0,
		KIND_EQUAL  = 2'd1,
		KIND_MINMAX = 2'd2,
		KIND_MEDIAN = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ALU_CMP,
		ALU_ADD,
		ALU_HALF
	} alu_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CMP,
		ST_PUT,
		ST_SUM_LO,
		ST_SUM_HI,
		ST_SUM_MA,
		ST_SUM_MB,
		ST_MEAN_ADD,
		ST_MEAN_HALF,
		ST_EMIT
	} state_t;

endpackage

[rtl/smm_if.sv]
// Channel interfaces: sample input, summary output, threshold write.
// Depends on smm_pkg for field widths and the kind type.
interface smm_in_if import smm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] sample;
	logic                    last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface smm_out_if import smm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	kind_t                   summary_kind;
	logic signed [SMP_W-1:0] min_value;
	logic signed [SMP_W-1:0] median_value;
	logic signed [SMP_W-1:0] max_value;
	logic [SEEN_W-1:0]       samples_seen;
	logic                    overflowed;

	modport source (output valid, output summary_kind, output min_value, output median_value,
		output max_value, output samples_seen, output overflowed, input ready);
	modport sink (input valid, input summary_kind, input min_value, input median_value,
		input max_value, input samples_seen, input overflowed, output ready);
endinterface

interface smm_cfg_if import smm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [THR_W-1:0] median_threshold;

	modport source (output valid, output median_threshold, input ready);
	modport sink (input valid, input median_threshold, output ready);
endinterface

[rtl/smm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/smm_alu.sv]
// Shared 65-bit adder: signed compare, middle sum, and halving toward zero.
// Depends on smm_pkg for the operation codes.
module smm_alu import smm_pkg::*; (
	input  alu_op_t          op,
	input  logic [SUM_W-1:0] a,
	input  logic [SUM_W-1:0] b,
	output logic [SUM_W-1:0] res
);

	logic [SUM_W-1:0] x;
	logic [SUM_W-1:0] y;
	logic             cin;

	always_comb begin
		case (op)
			ALU_CMP: begin
				// b - a; sign bit set means a > b
				x   = b;
				y   = ~a;
				cin = 1'b1;
			end
			ALU_ADD: begin
				x   = a;
				y   = b;
				cin = 1'b0;
			end
			ALU_HALF: begin
				// bias a negative sum by one so the shift truncates toward zero
				x   = a;
				y   = '0;
				cin = a[SUM_W-1];
			end
			default: begin
				x   = a;
				y   = b;
				cin = 1'b0;
			end
		endcase
		res = x + y + SUM_W'(cin);
	end

endmodule

[rtl/series_min_median_max_top.sv]
// Series summary top level: sequencer, sorted sample store and shared adder.
// Depends on smm_pkg, smm_if, smm_ram, smm_alu and the assertion header.
//
//  channel   | dir | word                                    | accepted when
//  ----------+-----+-----------------------------------------+----------------------
//  samples   | in  | sample, last_sample                     | valid && ready
//  summary   | out | kind, min, median, max, seen, overflow  | valid && ready
//  cfg       | in  | median_threshold                        | valid (ready always 1)
//
// An insertion into a non-empty store starts with the accepting cycle, then takes
// one shift step (one store read and one shift write) for each stored sample larger
// than the new one and one final compare or placement write; a word for an empty or
// full store is handled in its accepting cycle. The word with last_sample then goes
// through the store reads and adder passes, then waits for a free output register.
// Reset clears the sequencer, fill count, overflow flag and output valid; the
// store is not cleared, as only entries written in the current series are read.
// A stalled summary holds in the output register while the next series starts.
module series_min_median_max_top import smm_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	smm_in_if.sink    samples,
	smm_out_if.source summary,
	smm_cfg_if.sink   cfg
);

	`include "series_min_median_max_top_assert.svh"

	localparam int AW   = $clog2(MAX_SAMPLES);
	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int CMPW = (CW > THR_W) ? CW : THR_W;

	// sequencer state and series bookkeeping
	state_t                  state_q, state_d;
	logic [CW-1:0]           fill_q;
	logic                    ovf_q;
	logic [AW-1:0]           p_q;
	logic signed [SMP_W-1:0] x_q;
	logic                    last_q;
	logic [THR_W-1:0]        thr_q;

	// summary working registers
	logic signed [SMP_W-1:0] lo_q;
	logic signed [SMP_W-1:0] hi_q;
	logic signed [SMP_W-1:0] a_q;
	logic [SUM_W-1:0]        sum_q;
	logic signed [SMP_W-1:0] med_q;

	// output register
	logic                    out_valid_q;
	kind_t                   kind_q;
	logic signed [SMP_W-1:0] min_q;
	logic signed [SMP_W-1:0] medo_q;
	logic signed [SMP_W-1:0] max_q;
	logic [SEEN_W-1:0]       seen_q;
	logic                    ovfo_q;

	// store and adder wiring
	logic             we;
	logic [AW-1:0]    waddr;
	logic [SMP_W-1:0] wdata;
	logic [AW-1:0]    raddr;
	logic [SMP_W-1:0] rd_data;
	alu_op_t          alu_op;
	logic [SUM_W-1:0] alu_a;
	logic [SUM_W-1:0] alu_b;
	logic [SUM_W-1:0] alu_res;

	logic    in_acc;
	logic    full;
	logic    gt;
	logic    ins_done;
	logic    emit;
	logic    out_take;
	kind_t   kind_d;
	logic [CMPW-1:0] n_ext;
	logic [CMPW-1:0] thr_ext;

	assign in_acc   = samples.valid && samples.ready;
	assign full     = (fill_q == CW'(MAX_SAMPLES));
	assign gt       = alu_res[SUM_W-1];
	assign out_take = summary.valid && summary.ready;
	assign n_ext    = CMPW'(fill_q);
	assign thr_ext  = CMPW'(thr_q);

	smm_ram #(
		.WIDTH(SMP_W),
		.DEPTH(MAX_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd_data)
	);

	smm_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, store access and adder operands
	always_comb begin
		state_d  = state_q;
		we       = 1'b0;
		waddr    = p_q;
		wdata    = x_q;
		raddr    = '0;
		alu_op   = ALU_CMP;
		alu_a    = {rd_data[SMP_W-1], rd_data};
		alu_b    = {x_q[SMP_W-1], x_q};
		ins_done = 1'b0;
		emit     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (full) begin
						// drop the word, still summarize on the last one
						state_d = samples.last_sample ? ST_SUM_LO : ST_IDLE;
					end else if (fill_q == '0) begin
						we       = 1'b1;
						waddr    = '0;
						wdata    = samples.sample;
						ins_done = 1'b1;
						state_d  = samples.last_sample ? ST_SUM_LO : ST_IDLE;
					end else begin
						raddr   = AW'(fill_q - 1'b1);
						state_d = ST_CMP;
					end
				end
			end
			ST_CMP: begin
				we = 1'b1;
				if (gt) begin
					// shift the larger entry up one place
					wdata = rd_data;
					if (p_q == AW'(1)) begin
						state_d = ST_PUT;
					end else begin
						raddr = p_q - AW'(2);
					end
				end else begin
					ins_done = 1'b1;
					state_d  = last_q ? ST_SUM_LO : ST_IDLE;
				end
			end
			ST_PUT: begin
				we       = 1'b1;
				ins_done = 1'b1;
				state_d  = last_q ? ST_SUM_LO : ST_IDLE;
			end
			ST_SUM_LO: begin
				raddr   = '0;
				state_d = ST_SUM_HI;
			end
			ST_SUM_HI: begin
				raddr   = AW'(fill_q - 1'b1);
				state_d = ST_SUM_MA;
			end
			ST_SUM_MA: begin
				raddr   = AW'(fill_q >> 1);
				state_d = ST_SUM_MB;
			end
			ST_SUM_MB: begin
				raddr   = AW'((fill_q >> 1) - 1'b1);
				state_d = ST_MEAN_ADD;
			end
			ST_MEAN_ADD: begin
				alu_op  = ALU_ADD;
				alu_a   = {a_q[SMP_W-1], a_q};
				alu_b   = {rd_data[SMP_W-1], rd_data};
				state_d = ST_MEAN_HALF;
			end
			ST_MEAN_HALF: begin
				alu_op  = ALU_HALF;
				alu_a   = sum_q;
				alu_b   = '0;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || summary.ready) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// classify the finished series
	always_comb begin
		if (lo_q == hi_q) begin
			kind_d = (lo_q == '0) ? KIND_ZERO : KIND_EQUAL;
		end else if (n_ext >= thr_ext) begin
			kind_d = KIND_MEDIAN;
		end else begin
			kind_d = KIND_MINMAX;
		end
	end

	// control state: fill count, overflow, threshold, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			ovf_q       <= 1'b0;
			thr_q       <= THR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				thr_q <= cfg.median_threshold;
			end
			if (emit) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end else begin
				if (ins_done) begin
					fill_q <= fill_q + 1'b1;
				end
				if (in_acc && full) begin
					ovf_q <= 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			p_q    <= fill_q[AW-1:0];
			x_q    <= samples.sample;
			last_q <= samples.last_sample;
		end else if (state_q == ST_CMP && gt) begin
			p_q <= p_q - 1'b1;
		end
		case (state_q)
			ST_SUM_HI:    lo_q  <= rd_data;
			ST_SUM_MA:    hi_q  <= rd_data;
			ST_SUM_MB:    a_q   <= rd_data;
			ST_MEAN_ADD:  sum_q <= alu_res;
			ST_MEAN_HALF: med_q <= fill_q[0] ? a_q : alu_res[SUM_W-1:1];
			default: begin
			end
		endcase
		if (emit) begin
			kind_q <= kind_d;
			min_q  <= lo_q;
			max_q  <= hi_q;
			medo_q <= (kind_d == KIND_MEDIAN) ? med_q : '0;
			seen_q <= SEEN_W'(fill_q);
			ovfo_q <= ovf_q;
		end
	end

	assign samples.ready        = (state_q == ST_IDLE);
	assign cfg.ready            = 1'b1;
	assign summary.valid        = out_valid_q;
	assign summary.summary_kind = kind_q;
	assign summary.min_value    = min_q;
	assign summary.median_value = medo_q;
	assign summary.max_value    = max_q;
	assign summary.samples_seen = seen_q;
	assign summary.overflowed   = ovfo_q;

	`SMM_ASSERT_NOW(a_fill_cap, 1'b1, fill_q <= CW'(MAX_SAMPLES), "fill count above capacity")
	`SMM_ASSERT_NOW(a_cmp_ptr, state_q == ST_CMP, p_q != '0, "compare step at entry zero")
	`SMM_ASSERT_NOW(a_sum_nonempty, state_q == ST_SUM_LO, fill_q != '0, "summary of empty series")
	`SMM_ASSERT_NEXT(a_emit_clear, emit, fill_q == '0 && !ovf_q && out_valid_q,
		"series not cleared after summary")

endmodule

[dv/smm_summary_checker.sv]
// Summary checker for the series min/median/max block: watches all three channels,
// predicts each summary word and compares it with what the block delivers.
// Depends on smm_pkg and the channel interfaces in smm_if.
module smm_summary_checker import smm_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	smm_in_if    samples,
	smm_out_if   summary,
	smm_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		kind_t                   kind;
		logic signed [SMP_W-1:0] lo;
		logic signed [SMP_W-1:0] med;
		logic signed [SMP_W-1:0] hi;
		logic [SEEN_W-1:0]       seen;
		logic                    dropped;
	} summary_t;

	logic signed [SMP_W-1:0] kept[$];
	logic                    dropped;
	logic [THR_W-1:0]        threshold;
	summary_t                summaries_due[$];
	summary_t                want;
	int                      fails;

	// Keep the series in ascending order; drop the word once the store is full.
	function automatic void fold_in_sample(logic signed [SMP_W-1:0] x);
		int p;
		if (kept.size() >= MAX_SAMPLES) begin
			dropped = 1'b1;
			return;
		end
		p = kept.size();
		while (p > 0 && kept[p-1] > x)
			p--;
		kept.insert(p, x);
	endfunction

	function automatic summary_t summarize_series();
		summary_t                s;
		int                      n;
		logic signed [SUM_W-1:0] pair;
		n = kept.size();
		s.lo = kept[0];
		s.hi = kept[n-1];
		s.med = '0;
		s.seen = SEEN_W'(n);
		s.dropped = dropped;
		if (s.lo == s.hi) begin
			s.kind = (s.lo == 0) ? KIND_ZERO : KIND_EQUAL;
		end else if (n >= threshold) begin
			s.kind = KIND_MEDIAN;
			if (n % 2 != 0) begin
				s.med = kept[n/2];
			end else begin
				// 65-bit sum, signed divide truncates toward zero
				pair = kept[n/2-1] + kept[n/2];
				pair = pair / 2;
				s.med = pair[SMP_W-1:0];
			end
		end else begin
			s.kind = KIND_MINMAX;
		end
		return s;
	endfunction

	task automatic check_field(string what, logic signed [SMP_W-1:0] exp_v,
			logic signed [SMP_W-1:0] got_v);
		if (exp_v !== got_v) begin
			fails++;
			$display("%0t ns summary %s mismatch: expected %0d (0x%h), actual %0d (0x%h)",
				$time, what, exp_v, exp_v, got_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept.delete();
			summaries_due.delete();
			dropped = 1'b0;
			threshold = THR_RESET;
			fails = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready)
				threshold = cfg.median_threshold;
			// compare before predicting, so a word can never meet its own expectation
			if (summary.valid && summary.ready) begin
				if (summaries_due.size() == 0) begin
					fails++;
					$display("%0t ns summary word with nothing expected: kind %0d seen %0d",
						$time, summary.summary_kind, summary.samples_seen);
				end else begin
					want = summaries_due.pop_front();
					check_field("kind", want.kind, summary.summary_kind);
					check_field("min", want.lo, summary.min_value);
					check_field("median", want.med, summary.median_value);
					check_field("max", want.hi, summary.max_value);
					check_field("samples_seen", want.seen, summary.samples_seen);
					check_field("overflowed", want.dropped, summary.overflowed);
				end
			end
			if (samples.valid && samples.ready) begin
				fold_in_sample(samples.sample);
				if (samples.last_sample) begin
					summaries_due.push_back(summarize_series());
					kept.delete();
					dropped = 1'b0;
				end
			end
			fail_count <= fails;
			pending <= summaries_due.size();
		end
	end

endmodule

[dv/tb_series_min_median_max_top.sv]
// Testbench top for the series min/median/max block: clock, reset, sample and
// threshold stimulus, summary receiver and the verdict.
// Depends on smm_pkg, smm_if, the block's RTL and smm_summary_checker.
module tb_series_min_median_max_top import smm_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// Longest insertion shifts every stored sample once, plus the summary passes;
	// hold this long after the last summary before touching the register.
	localparam int DRAIN_CYCLES = 300;
	localparam int PHASE_WORDS  = 70;
	localparam logic signed [SMP_W-1:0] S_MIN = {1'b1, {(SMP_W-1){1'b0}}};
	localparam logic signed [SMP_W-1:0] S_MAX = {1'b0, {(SMP_W-1){1'b1}}};

	// How the values of one series are drawn.
	typedef enum logic [2:0] {
		MIX_ZERO,
		MIX_SAME,
		MIX_POOL,
		MIX_EDGE,
		MIX_SMALL,
		MIX_WIDE
	} mix_t;

	logic clk;
	logic arst_n;

	smm_in_if  samples();
	smm_out_if summary();
	smm_cfg_if cfg();

	int fail_count;
	int pending;

	series_min_median_max_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.summary (summary),
		.cfg     (cfg)
	);

	smm_summary_checker #(.MAX_SAMPLES(MAX_SAMPLES_DEF)) summary_watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.summary    (summary),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Sender and receiver idling knobs, changed per phase.
	logic sender_gaps;
	logic sink_stalls;
	int   burst_left;
	int   ready_run;

	int   words_sent;
	int   series_sent;
	int   settings_used;

	logic signed [SMP_W-1:0] pool[3];
	logic signed [SMP_W-1:0] batch[$];

	// Receiver: alternate runs of ready high and ready low. When stalls are off,
	// hold ready high so the summary register drains every cycle.
	always @(posedge clk) begin
		if (!sink_stalls) begin
			summary.ready <= 1'b1;
			ready_run = 0;
		end else if (ready_run > 0) begin
			ready_run--;
		end else if (summary.ready) begin
			summary.ready <= 1'b0;
			ready_run = $urandom_range(0, 19);
		end else begin
			summary.ready <= 1'b1;
			ready_run = $urandom_range(0, 7);
		end
	end

	// Offer one sample word and hold it until the block takes it. Bursts of
	// back-to-back words are separated by random gaps with valid low; within a
	// burst valid stays high and only the payload advances.
	task automatic send_word(logic signed [SMP_W-1:0] value, logic last);
		int gap;
		if (burst_left == 0) begin
			gap = sender_gaps ? $urandom_range(0, 12) : 0;
			if (gap > 0) begin
				samples.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		samples.valid <= 1'b1;
		samples.sample <= value;
		samples.last_sample <= last;
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
		burst_left--;
		words_sent++;
	endtask

	// Send the words queued in batch as one series, last flag on the final one.
	task automatic send_batch();
		foreach (batch[i])
			send_word(batch[i], i == batch.size() - 1);
		series_sent++;
	endtask

	function automatic logic signed [SMP_W-1:0] draw_value(mix_t mix);
		int k;
		case (mix)
			MIX_ZERO: return '0;
			MIX_SAME: return pool[0];
			MIX_POOL: return pool[$urandom_range(0, 2)];
			MIX_EDGE: begin
				case ($urandom_range(0, 6))
					0: return S_MIN;
					1: return S_MIN + 1;
					2: return -1;
					3: return 0;
					4: return 1;
					5: return S_MAX - 1;
					default: return S_MAX;
				endcase
			end
			MIX_SMALL: begin
				k = $urandom_range(0, 8);
				return k - 4;
			end
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_series(int len, mix_t mix);
		for (int i = 0; i < len; i++)
			send_word(draw_value(mix), i == len - 1);
		series_sent++;
	endtask

	// Drop valid and wait for every predicted summary, then let the block settle.
	task automatic drain();
		samples.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Threshold write; only called with the block idle.
	task automatic write_threshold(logic [THR_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.median_threshold <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		settings_used++;
	endtask

	initial begin : stimulus
		int               start;
		int               len;
		int               pick;
		mix_t             mix;
		logic [THR_W-1:0] phase_thr[7];

		// Every input known from time zero.
		arst_n = 1'b0;
		samples.valid = 1'b0;
		samples.sample = '0;
		samples.last_sample = 1'b0;
		cfg.valid = 1'b0;
		cfg.median_threshold = THR_RESET;
		summary.ready = 1'b0;
		sender_gaps = 1'b1;
		sink_stalls = 1'b1;
		burst_left = 0;
		ready_run = 0;
		words_sent = 0;
		series_sent = 0;
		settings_used = 0;
		phase_thr = '{9'd1, 9'd0, 9'd256, 9'd2, 9'd511, 9'd0, 9'd0};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed series under the reset threshold of 10.
		batch = '{0};
		send_batch();                  // lone zero: all-zero kind
		batch = '{S_MAX};
		send_batch();                  // lone extreme: all-equal kind
		batch = '{S_MIN, S_MAX};
		send_batch();                  // full span, too short for a median
		batch = '{0, 0, 0};
		send_batch();
		batch = '{-1, -1, -1};
		send_batch();
		// ten words reach the threshold: even count, middle pair 0 and 1
		batch = '{S_MAX, S_MAX, S_MIN, S_MIN, -3, 4, 7, -1, 0, 1};
		send_batch();

		// Threshold of 2: negative odd pair sums must truncate toward zero.
		drain();
		write_threshold(9'd2);
		batch = '{-3, -2};
		send_batch();
		batch = '{S_MIN, S_MIN + 1};
		send_batch();

		// Random phases, each under its own threshold, drained in between so
		// the sender pauses until every summary has come back.
		for (int ph = 0; ph < 7; ph++) begin
			drain();
			write_threshold(ph >= 5 ? THR_W'($urandom_range(1, 20)) : phase_thr[ph]);
			// phase 3 runs with no idling on either side
			sender_gaps = (ph != 3);
			sink_stalls <= (ph != 3);
			start = words_sent;

			// threshold 0: overflow the store, last word among the dropped ones
			if (ph == 1)
				send_series(MAX_SAMPLES_DEF + 3, MIX_EDGE);
			// threshold 256: exactly fill the store, median over all of it
			if (ph == 2) begin
				pool[0] = {$urandom, $urandom};
				send_series(MAX_SAMPLES_DEF, MIX_WIDE);
			end

			while (words_sent - start < PHASE_WORDS) begin
				pick = $urandom_range(0, 11);
				case (pick)
					0: mix = MIX_ZERO;
					1: mix = MIX_SAME;
					2, 3: mix = MIX_POOL;
					4, 5: mix = MIX_EDGE;
					6, 7: mix = MIX_SMALL;
					default: mix = MIX_WIDE;
				endcase
				foreach (pool[i])
					pool[i] = ($urandom_range(0, 1) != 0) ? {$urandom, $urandom}
						: SMP_W'($urandom_range(0, 6)) - 3;
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 12);
				send_series(len, mix);
			end
		end

		drain();
		$display("run covered %0d sample words in %0d series over %0d threshold writes,",
			words_sent, series_sent, settings_used);
		$display("including a full store, a dropped last word and extreme pair means");
		if (fail_count == 0 && pending == 0)
			$display("tb_series_min_median_max_top: clean");
		else
			$display("tb_series_min_median_max_top: errors");
		$finish;
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#20_000_000;
		$display("tb_series_min_median_max_top: errors");
		$finish;
	end

endmodule
